/* hdl/cfbc_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cfbc_pkg
// Shared types and constants of the cubemap face box cull block.
// ---------------------------------------------------------------------------
package cfbc_pkg;

	localparam int DATA_W         = 32;
	localparam int FACE_W         = 3;
	localparam int ELEM_W         = 4;
	localparam int PLANE_W        = 31;
	localparam int MASK_W         = 6;
	localparam int AXES           = 3;
	localparam int CORNERS        = 8;
	localparam int FACE_COUNT_DEF = 6;
	localparam int FRAC_BITS_DEF  = 16;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	// register index, decoded from paddr[2]
	localparam logic REG_NEAR = 1'b0;
	localparam logic REG_FAR  = 1'b1;

	// one word as it moves down the chain of face cells
	typedef struct packed {
		logic                           vld;
		logic                           cmd;
		logic [FACE_W-1:0]              face;
		logic [ELEM_W-1:0]              elem;
		logic [DATA_W-1:0]              value;
		logic [AXES-1:0][DATA_W-1:0]    lo;
		logic [AXES-1:0][DATA_W-1:0]    hi;
	} item_t;

endpackage : cfbc_pkg
`default_nettype wire

/* hdl/cfbc_cell.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cfbc_cell
// One face of the cull chain: holds the face view matrix, tests the box in
// three stages (products, corner sums, plane compares) and passes it on.
// ---------------------------------------------------------------------------
module cfbc_cell
	import cfbc_pkg::*;
#(
	parameter int FACE_ID    = 0,
	parameter int FACE_COUNT = FACE_COUNT_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  adv,
	input  wire logic [PLANE_W-1:0]    near_plane,
	input  wire logic [PLANE_W-1:0]    far_plane,
	input  wire item_t                 item_in,
	input  wire logic [FACE_COUNT-1:0] mask_in,
	output      item_t                 item_out,
	output      logic [FACE_COUNT-1:0] mask_out
);

	localparam int FULL_W = 2 * DATA_W;
	localparam int PROD_W = FULL_W - FRAC_BITS;
	localparam int SUM_W  = PROD_W + 3;

	// matrix columns 0..3, rows 0..2 (x, y, z); column 3 is translation
	logic [DATA_W-1:0] m_q [4][AXES];

	logic signed [FULL_W-1:0] full_lo [AXES][AXES];
	logic signed [FULL_W-1:0] full_hi [AXES][AXES];
	logic signed [PROD_W-1:0] p_lo_s1 [AXES][AXES];
	logic signed [PROD_W-1:0] p_hi_s1 [AXES][AXES];
	logic        [DATA_W-1:0] t_s1 [AXES];
	item_t                    item_s1, item_s2, item_s3;
	logic [FACE_COUNT-1:0]    mask_s1, mask_s2, mask_s3;

	logic signed [SUM_W-1:0]  sum_d  [CORNERS][AXES];
	logic signed [SUM_W-1:0]  sum_s2 [CORNERS][AXES];
	logic                     sees;
	logic                     load_hit;

	assign load_hit = item_in.vld && (item_in.cmd == CMD_LOAD)
		&& (item_in.face == FACE_W'(FACE_ID)) && (item_in.elem[1:0] != 2'b11);

	always_ff @(posedge clk) begin
		if (adv && load_hit) begin
			m_q[item_in.elem[3:2]][item_in.elem[1:0]] <= item_in.value;
		end
	end

	always_comb begin
		for (int c = 0; c < AXES; c++) begin
			for (int r = 0; r < AXES; r++) begin
				full_lo[c][r] = $signed(item_in.lo[c]) * $signed(m_q[c][r]);
				full_hi[c][r] = $signed(item_in.hi[c]) * $signed(m_q[c][r]);
			end
		end
	end

	// stage 1: truncated products, both box extents per axis
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < AXES; c++) begin
				for (int r = 0; r < AXES; r++) begin
					p_lo_s1[c][r] <= full_lo[c][r][FULL_W-1:FRAC_BITS];
					p_hi_s1[c][r] <= full_hi[c][r][FULL_W-1:FRAC_BITS];
				end
				t_s1[c] <= m_q[3][c];
			end
			mask_s1 <= mask_in;
		end
	end

	// stage 2: view-space coordinates of the eight corners
	always_comb begin
		for (int k = 0; k < CORNERS; k++) begin
			for (int r = 0; r < AXES; r++) begin
				sum_d[k][r] = (k[2] ? SUM_W'(p_hi_s1[0][r]) : SUM_W'(p_lo_s1[0][r]))
					+ (k[1] ? SUM_W'(p_hi_s1[1][r]) : SUM_W'(p_lo_s1[1][r]))
					+ (k[0] ? SUM_W'(p_hi_s1[2][r]) : SUM_W'(p_lo_s1[2][r]))
					+ SUM_W'($signed(t_s1[r]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2  <= sum_d;
			mask_s2 <= mask_s1;
		end
	end

	// stage 3: face rejected when all corners are beyond one common plane
	always_comb begin
		logic signed [SUM_W-1:0] zn, zf, x, y, z, nz;
		logic o_near, o_far, o_left, o_right, o_bot, o_top;
		zn = SUM_W'($signed({1'b0, near_plane}));
		zf = SUM_W'($signed({1'b0, far_plane}));
		o_near = 1'b1; o_far = 1'b1; o_left = 1'b1;
		o_right = 1'b1; o_bot = 1'b1; o_top = 1'b1;
		for (int k = 0; k < CORNERS; k++) begin
			x  = sum_s2[k][0];
			y  = sum_s2[k][1];
			z  = sum_s2[k][2];
			nz = -z;
			o_near  = o_near  && (z < zn);
			o_far   = o_far   && (z > zf);
			o_left  = o_left  && (x < nz);
			o_right = o_right && (x > z);
			o_bot   = o_bot   && (y < nz);
			o_top   = o_top   && (y > z);
		end
		sees = !(o_near || o_far || o_left || o_right || o_bot || o_top);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mask_s3 <= mask_s2 | (FACE_COUNT'(sees) << FACE_ID);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
			item_s2 <= '0;
			item_s3 <= '0;
		end else if (adv) begin
			item_s1 <= item_in;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
		end
	end

	assign item_out = item_s3;
	assign mask_out = mask_s3;

endmodule : cfbc_cell
`default_nettype wire

/* hdl/cubemap_face_box_cull.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cubemap_face_box_cull
// Conservative box culling against the cubemap face frusta.
// ---------------------------------------------------------------------------
// Each word (matrix load or box test) walks a chain of FACE_COUNT face cells,
// three register stages per cell (multiply, corner sums, plane compares),
// plus one output register. One word is taken every cycle while the chain
// advances. Loads travel the same chain, so every test sees exactly the
// loads taken before it, and the whole chain stalls only while a finished
// mask waits at the output.
// ---------------------------------------------------------------------------
module cubemap_face_box_cull
	import cfbc_pkg::*;
#(
	parameter int FACE_COUNT = FACE_COUNT_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output      logic [DATA_W-1:0] prdata,
	output      logic              pready,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic              command,
	input  wire logic [FACE_W-1:0] face_index,
	input  wire logic [ELEM_W-1:0] element_index,
	input  wire logic [DATA_W-1:0] element_value,
	input  wire logic [DATA_W-1:0] box_min_x,
	input  wire logic [DATA_W-1:0] box_min_y,
	input  wire logic [DATA_W-1:0] box_min_z,
	input  wire logic [DATA_W-1:0] box_max_x,
	input  wire logic [DATA_W-1:0] box_max_y,
	input  wire logic [DATA_W-1:0] box_max_z,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      logic [MASK_W-1:0] face_mask
);

	localparam longint ONE       = longint'(1) << FRAC_BITS;
	localparam longint NEAR_INIT = (ONE * 5 + 50) / 100;
	localparam longint FAR_INIT  = ONE * 100;

	logic [PLANE_W-1:0] near_q, far_q;
	logic               adv;
	logic               out_valid_q;
	logic [MASK_W-1:0]  face_mask_q;

	item_t                 item_c [FACE_COUNT+1];
	logic [FACE_COUNT-1:0] mask_c [FACE_COUNT+1];
	logic [MASK_W+FACE_COUNT-1:0] mask_wide;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FAR) ? {1'b0, far_q} : {1'b0, near_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= PLANE_W'(NEAR_INIT);
			far_q  <= PLANE_W'(FAR_INIT);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_NEAR: near_q <= pwdata[PLANE_W-1:0];
				REG_FAR:  far_q  <= pwdata[PLANE_W-1:0];
				default:  ;
			endcase
		end
	end

	// chain advances unless a mask waits at the output
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_comb begin
		item_c[0]       = '0;
		item_c[0].vld   = in_valid;
		item_c[0].cmd   = command;
		item_c[0].face  = face_index;
		item_c[0].elem  = element_index;
		item_c[0].value = element_value;
		item_c[0].lo[0] = box_min_x;
		item_c[0].lo[1] = box_min_y;
		item_c[0].lo[2] = box_min_z;
		item_c[0].hi[0] = box_max_x;
		item_c[0].hi[1] = box_max_y;
		item_c[0].hi[2] = box_max_z;
	end
	assign mask_c[0] = '0;

	for (genvar f = 0; f < FACE_COUNT; f++) begin : g_cell
		cfbc_cell #(
			.FACE_ID    (f),
			.FACE_COUNT (FACE_COUNT),
			.FRAC_BITS  (FRAC_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.near_plane (near_q),
			.far_plane  (far_q),
			.item_in    (item_c[f]),
			.mask_in    (mask_c[f]),
			.item_out   (item_c[f+1]),
			.mask_out   (mask_c[f+1])
		);
	end

	assign mask_wide = {MASK_W'(0), mask_c[FACE_COUNT]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= item_c[FACE_COUNT].vld && (item_c[FACE_COUNT].cmd == CMD_TEST);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			face_mask_q <= mask_wide[MASK_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign face_mask = face_mask_q;

endmodule : cubemap_face_box_cull
`default_nettype wire

/* sim/cubemap_face_box_cull_test.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// cubemap_face_box_cull_test
// Drives view matrix loads and box tests through the block, predicts each
// face mask from a local copy of the matrix store and plane registers, and
// compares every mask in order. Plane registers change between phases.
// ---------------------------------------------------------------------------
module cubemap_face_box_cull_test;
	import cfbc_pkg::*;

	localparam int NFACES    = 6;
	localparam int QBITS     = 16;
	localparam int LATENCY   = 3 * NFACES + 1;
	localparam int WATCHDOG  = 2000;
	localparam int NRANDOM   = 928;
	localparam logic [2:0] ADDR_NEAR = 3'd0;
	localparam logic [2:0] ADDR_FAR  = 3'd4;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [2:0]        paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid, in_ready;
	logic              command;
	logic [FACE_W-1:0] face_index;
	logic [ELEM_W-1:0] element_index;
	logic [DATA_W-1:0] element_value;
	logic [DATA_W-1:0] box_min_x, box_min_y, box_min_z;
	logic [DATA_W-1:0] box_max_x, box_max_y, box_max_z;
	logic              out_valid, out_ready;
	logic [MASK_W-1:0] face_mask;

	cubemap_face_box_cull dut (.*);

	// predictor state
	logic signed [DATA_W-1:0] matrix_words [NFACES*16];
	logic [PLANE_W-1:0]       near_z, far_z;
	logic [MASK_W-1:0]        mask_queue [$];

	int  errors;
	int  idle_cycles;
	int  out_count;
	logic [MASK_W-1:0] last_mask;
	bit  calm;
	bit  out_stall_en;

	typedef struct {
		logic              cmd;
		logic [FACE_W-1:0] face;
		logic [ELEM_W-1:0] elem;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] lo [3];
		logic [DATA_W-1:0] hi [3];
		bit                has_mask;
		logic [MASK_W-1:0] mask;
	} word_t;

	word_t directed [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [63:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p >>> QBITS;
	endfunction

	function automatic logic [MASK_W-1:0] cull_mask(word_t w);
		logic [MASK_W-1:0] m;
		logic signed [31:0] c [3];
		logic signed [63:0] x, y, z;
		bit on, of, ol, orr, ob, ot;
		int b;
		m = '0;
		for (int f = 0; f < NFACES; f++) begin
			on = 1; of = 1; ol = 1; orr = 1; ob = 1; ot = 1;
			b = f * 16;
			for (int k = 0; k < 8; k++) begin
				c[0] = k[2] ? w.hi[0] : w.lo[0];
				c[1] = k[1] ? w.hi[1] : w.lo[1];
				c[2] = k[0] ? w.hi[2] : w.lo[2];
				x = qmul(c[0], matrix_words[b]) + qmul(c[1], matrix_words[b+4])
					+ qmul(c[2], matrix_words[b+8]) + 64'(matrix_words[b+12]);
				y = qmul(c[0], matrix_words[b+1]) + qmul(c[1], matrix_words[b+5])
					+ qmul(c[2], matrix_words[b+9]) + 64'(matrix_words[b+13]);
				z = qmul(c[0], matrix_words[b+2]) + qmul(c[1], matrix_words[b+6])
					+ qmul(c[2], matrix_words[b+10]) + 64'(matrix_words[b+14]);
				on  &= z < $signed({33'd0, near_z});
				of  &= z > $signed({33'd0, far_z});
				ol  &= x < -z;
				orr &= x > z;
				ob  &= y < -z;
				ot  &= y > z;
			end
			if (!(on || of || ol || orr || ob || ot)) m[f] = 1'b1;
		end
		return m;
	endfunction

	// predictor update on acceptance and mask check on output
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (in_valid && in_ready) begin
			if (command == CMD_LOAD) begin
				if (face_index < NFACES && element_index[1:0] != 2'b11)
					matrix_words[face_index*16 + element_index] = element_value;
			end else begin
				word_t w;
				w.lo[0] = box_min_x; w.lo[1] = box_min_y; w.lo[2] = box_min_z;
				w.hi[0] = box_max_x; w.hi[1] = box_max_y; w.hi[2] = box_max_z;
				mask_queue = {mask_queue, cull_mask(w)};
			end
		end
		if (out_valid && out_ready) begin
			out_count++;
			last_mask = face_mask;
			if (mask_queue.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected mask %h", face_mask);
			end else begin
				logic [MASK_W-1:0] e;
				e = mask_queue.pop_front();
				if (e !== face_mask) begin
					errors++;
					if (errors <= 10) $display("mask mismatch: expected %h actual %h", e, face_mask);
				end
			end
		end
	end

	// result side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (calm || !out_stall_en) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		out_stall_en = 1'b1;
		forever begin
			repeat ($urandom_range(10, 40)) @(posedge clk);
			out_stall_en = ($urandom_range(0, 2) == 0);
		end
	end

	initial begin
		@(posedge clk);
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG) begin
				$display("cubemap_face_box_cull test failed");
				$finish;
			end
		end
	end

	task automatic plane_write(logic [2:0] addr, logic [DATA_W-1:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_NEAR) near_z = data[PLANE_W-1:0];
		else far_z = data[PLANE_W-1:0];
	endtask

	task automatic send_word(word_t w);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= w.cmd; face_index <= w.face; element_index <= w.elem;
		element_value <= w.value;
		box_min_x <= w.lo[0]; box_min_y <= w.lo[1]; box_min_z <= w.lo[2];
		box_max_x <= w.hi[0]; box_max_y <= w.hi[1]; box_max_z <= w.hi[2];
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (mask_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'h0001_0000;
			2: return 32'hffff_0000;
			default: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
		endcase
	endfunction

	function automatic word_t load_word(int f, int e, logic [31:0] v);
		word_t w;
		w.cmd = CMD_LOAD; w.face = FACE_W'(f); w.elem = ELEM_W'(e); w.value = v;
		for (int i = 0; i < 3; i++) begin
			w.lo[i] = $urandom(); w.hi[i] = $urandom();
		end
		w.has_mask = 0; w.mask = '0;
		return w;
	endfunction

	function automatic word_t box_word(logic [31:0] l0, l1, l2, h0, h1, h2);
		word_t w;
		w.cmd = CMD_TEST; w.face = FACE_W'($urandom()); w.elem = ELEM_W'($urandom());
		w.value = $urandom();
		w.lo[0] = l0; w.lo[1] = l1; w.lo[2] = l2;
		w.hi[0] = h0; w.hi[1] = h1; w.hi[2] = h2;
		w.has_mask = 0; w.mask = '0;
		return w;
	endfunction

	task automatic load_random_matrices;
		for (int f = 0; f < NFACES; f++)
			for (int e = 0; e < 16; e++)
				send_word(load_word(f, e, rand_elem()));
	endtask

	task automatic run_random(int n);
		word_t w;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				w = load_word($urandom_range(0, 7), $urandom_range(0, 15), rand_elem());
			else
				w = box_word(rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord());
			send_word(w);
		end
	endtask

	initial begin
		word_t w;
		logic [MASK_W-1:0] exp_mask;
		int seen;
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; command = CMD_LOAD; face_index = '0; element_index = '0;
		element_value = '0;
		box_min_x = '0; box_min_y = '0; box_min_z = '0;
		box_max_x = '0; box_max_y = '0; box_max_z = '0;
		errors = 0; idle_cycles = 0; calm = 0; out_count = 0; last_mask = '0;
		near_z = 31'd3277; far_z = 31'd6553600;
		for (int i = 0; i < NFACES*16; i++) matrix_words[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero matrices put every z at 0, below near: all culled
		for (int f = 0; f < NFACES; f++)
			for (int e = 0; e < 16; e++)
				if (e[1:0] != 2'b11) directed = {directed, load_word(f, e, 32'd0)};
		w = box_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		w.has_mask = 1; w.mask = '0;
		directed = {directed, w};
		// ignored loads: unused element and out of range face
		directed = {directed, load_word(0, 3, 32'h7fff_ffff)};
		directed = {directed, load_word(6, 14, 32'h0001_0000)};
		directed = {directed, load_word(7, 14, 32'h0001_0000)};
		w.mask = '0;
		directed = {directed, w};
		// identity-like face 0: translate z forward by five units
		directed = {directed, load_word(0, 0, 32'h0001_0000)};
		directed = {directed, load_word(0, 5, 32'h0001_0000)};
		directed = {directed, load_word(0, 10, 32'h0001_0000)};
		directed = {directed, load_word(0, 14, 32'h0005_0000)};
		w = box_word(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		w.has_mask = 0;
		directed = {directed, w};
		// inverted box
		directed = {directed, box_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'hffff_0000, 32'hffff_0000, 32'hffff_0000)};
		directed = {directed, box_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000)};
		foreach (directed[i]) begin
			seen = out_count;
			send_word(directed[i]);
			if (directed[i].has_mask) begin
				drain();
				exp_mask = directed[i].mask;
				if (out_count == seen || last_mask !== exp_mask) begin
					errors++;
					if (errors <= 10)
						$display("mask mismatch: expected %h actual %h", exp_mask, last_mask);
				end
			end
		end
		drain();

		plane_write(ADDR_NEAR, 32'd0);
		plane_write(ADDR_FAR, 32'h7fff_ffff);
		load_random_matrices();
		run_random(NRANDOM / 4);
		drain();

		plane_write(ADDR_NEAR, 32'hffff_ffff);
		plane_write(ADDR_FAR, 32'd0);
		run_random(NRANDOM / 8);
		drain();

		plane_write(ADDR_NEAR, $urandom_range(0, 32'h0002_0000));
		plane_write(ADDR_FAR, $urandom_range(32'h0010_0000, 32'h7fff_ffff));
		load_random_matrices();
		run_random(NRANDOM / 2);
		drain();

		plane_write(ADDR_NEAR, 32'd3277);
		plane_write(ADDR_FAR, 32'd6553600);
		calm = 1;
		run_random(NRANDOM / 8);
		drain();

		if (errors == 0) begin
			$display("cubemap_face_box_cull test passed");
		end else begin
			$display("cubemap_face_box_cull test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
